// File: rtl/c6502_pkg.sv
// ----------------------------------------------------------------------------
// 6502 subset package
// Sequencer steps, decode classes and status bit positions.
// ----------------------------------------------------------------------------
package c6502_pkg;

  typedef enum logic [2:0] {
    SqStart, SqOpcode, SqOp1, SqOp2, SqPtrl, SqPtrh, SqData, SqPush
  } seq_e;

  typedef enum logic [3:0] {
    MImp, MImm, MRel, MZp, MZpx, MZpy, MAbs, MAbx, MAby, MIzx, MIzy
  } mode_e;

  typedef enum logic [3:0] {
    ALda, ALdx, ALdy, ASta, AStx, ASty, ABit, ABr, AClc, ASec,
    AInx, AIny, ANop, AJmp, AJsr
  } act_e;

  typedef struct packed {
    logic  known;
    mode_e mode;
    act_e  act;
  } dec_t;

  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  localparam logic [15:0] ResetStart  = 16'hC000;
  localparam logic [7:0]  ResetSp     = 8'hFD;
  localparam logic [7:0]  ResetStatus = 8'h24;

  localparam logic [7:0] OpBcc = 8'h90;
  localparam logic [7:0] OpBcs = 8'hB0;
  localparam logic [7:0] OpBeq = 8'hF0;
  localparam logic [7:0] OpBne = 8'hD0;

  function automatic dec_t decode(input logic [7:0] op);
    dec_t r;
    r = '{known: 1'b1, mode: MImp, act: ANop};
    unique case (op)
      8'hA9: begin r.act = ALda; r.mode = MImm; end
      8'hA5: begin r.act = ALda; r.mode = MZp; end
      8'hB5: begin r.act = ALda; r.mode = MZpx; end
      8'hAD: begin r.act = ALda; r.mode = MAbs; end
      8'hBD: begin r.act = ALda; r.mode = MAbx; end
      8'hB9: begin r.act = ALda; r.mode = MAby; end
      8'hA1: begin r.act = ALda; r.mode = MIzx; end
      8'hB1: begin r.act = ALda; r.mode = MIzy; end
      8'h85: begin r.act = ASta; r.mode = MZp; end
      8'h95: begin r.act = ASta; r.mode = MZpx; end
      8'h8D: begin r.act = ASta; r.mode = MAbs; end
      8'h9D: begin r.act = ASta; r.mode = MAbx; end
      8'h99: begin r.act = ASta; r.mode = MAby; end
      8'h81: begin r.act = ASta; r.mode = MIzx; end
      8'h91: begin r.act = ASta; r.mode = MIzy; end
      8'hA2: begin r.act = ALdx; r.mode = MImm; end
      8'hA6: begin r.act = ALdx; r.mode = MZp; end
      8'hAE: begin r.act = ALdx; r.mode = MAbs; end
      8'hB6: begin r.act = ALdx; r.mode = MZpy; end
      8'hBE: begin r.act = ALdx; r.mode = MAby; end
      8'hA0: begin r.act = ALdy; r.mode = MImm; end
      8'hA4: begin r.act = ALdy; r.mode = MZp; end
      8'hAC: begin r.act = ALdy; r.mode = MAbs; end
      8'hB4: begin r.act = ALdy; r.mode = MZpx; end
      8'hBC: begin r.act = ALdy; r.mode = MAbx; end
      8'h86: begin r.act = AStx; r.mode = MZp; end
      8'h96: begin r.act = AStx; r.mode = MZpy; end
      8'h8E: begin r.act = AStx; r.mode = MAbs; end
      8'h84: begin r.act = ASty; r.mode = MZp; end
      8'h94: begin r.act = ASty; r.mode = MZpx; end
      8'h8C: begin r.act = ASty; r.mode = MAbs; end
      8'h24: begin r.act = ABit; r.mode = MZp; end
      8'h2C: begin r.act = ABit; r.mode = MAbs; end
      8'h90, 8'hB0, 8'hF0, 8'hD0, 8'h70: begin r.act = ABr; r.mode = MRel; end
      8'h18: r.act = AClc;
      8'h38: r.act = ASec;
      8'hE8: r.act = AInx;
      8'hC8: r.act = AIny;
      8'hEA: r.act = ANop;
      8'h4C: begin r.act = AJmp; r.mode = MAbs; end
      8'h20: begin r.act = AJsr; r.mode = MAbs; end
      default: r.known = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] cost_of(input mode_e mode, input act_e act,
                                         input logic crossed);
    logic c;
    logic [2:0] r;
    c = crossed | (act == ASta);
    unique case (mode)
      MImm:             r = 3'd2;
      MZp:              r = 3'd3;
      MZpx, MZpy, MAbs: r = 3'd4;
      MAbx, MAby:       r = c ? 3'd5 : 3'd4;
      MIzx:             r = 3'd6;
      MIzy:             r = c ? 3'd6 : 3'd5;
      default:          r = 3'd2;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/cpu6502_subset_bus_core.sv
// ----------------------------------------------------------------------------
// 6502 subset bus core
// Each request gives one register snapshot and, unless halted, one bus access.
// An accepted request's result is registered in the output register.
// Throughput: one request per cycle while in_stall_o is low; the step sequencer
// and register file update in the same cycle as the request is taken.
// Reset: asynchronous, low active; registers take 6502 reset values and the
// next request fetches the opcode at start_address.
// ----------------------------------------------------------------------------
module cpu6502_subset_bus_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_start_address_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        bus_valid_o,
  output logic [15:0] bus_address_o,
  output logic        bus_write_o,
  output logic [7:0]  bus_write_data_o,
  output logic        retired_o,
  output logic [2:0]  cycle_cost_o,
  output logic        halted_o,
  output logic [7:0]  acc_value_o,
  output logic [7:0]  x_value_o,
  output logic [7:0]  y_value_o,
  output logic [7:0]  status_value_o
);

  c6502_pkg::seq_e seq_q, seq_d;
  logic [15:0] start_q, pc_q, pc_d, ea_q, ea_d;
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, p_q, p_d;
  logic [7:0]  op_q, op_d, pl_q, pl_d;
  logic        pc_x_q, pc_x_d, halt_q, halt_d;
  logic        ov_q;
  logic        bv_d, bw_d, ret_d;
  logic [15:0] ba_d;
  logic [7:0]  bd_d;
  logic [2:0]  cost_d;
  logic        bv_q, bw_q, ret_q;
  logic [15:0] ba_q;
  logic [7:0]  bd_q;
  logic [2:0]  cost_q;
  logic        accept;
  c6502_pkg::dec_t dc, dn;
  logic [7:0]  d, idx, pl1;
  logic [15:0] base, eidx, tgt, ret_addr;
  logic        taken;
  logic [2:0]  bcost;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = ov_q && out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign d           = read_data_i;

  always_comb begin
    dc = c6502_pkg::decode(op_q);
    dn = c6502_pkg::decode(d);
    seq_d = seq_q; pc_d = pc_q; ea_d = ea_q; a_d = a_q; x_d = x_q; y_d = y_q;
    sp_d = sp_q; p_d = p_q; op_d = op_q; pl_d = pl_q; pc_x_d = pc_x_q;
    halt_d = halt_q;
    bv_d = 1'b0; ba_d = '0; bw_d = 1'b0; bd_d = '0; ret_d = 1'b0; cost_d = '0;
    idx = '0; base = '0; eidx = '0; tgt = '0; taken = 1'b0; bcost = 3'd2;
    pl1 = pl_q + 8'd1;
    ret_addr = pc_q - 16'd1;
    if (!halt_q) begin
      unique case (seq_q)
        c6502_pkg::SqOpcode: begin
          op_d = d; pc_x_d = 1'b0;
          if (!dn.known) begin
            halt_d = 1'b1;
          end else if (dn.mode == c6502_pkg::MImp) begin
            if (dn.act == c6502_pkg::AClc) p_d[c6502_pkg::FlagC] = 1'b0;
            if (dn.act == c6502_pkg::ASec) p_d[c6502_pkg::FlagC] = 1'b1;
            if (dn.act == c6502_pkg::AInx) begin
              x_d = x_q + 8'd1;
              p_d[c6502_pkg::FlagZ] = (x_d == 8'd0); p_d[c6502_pkg::FlagN] = x_d[7];
            end
            if (dn.act == c6502_pkg::AIny) begin
              y_d = y_q + 8'd1;
              p_d[c6502_pkg::FlagZ] = (y_d == 8'd0); p_d[c6502_pkg::FlagN] = y_d[7];
            end
            bv_d = 1'b1; ba_d = pc_q; ret_d = 1'b1; cost_d = 3'd2;
            pc_d = pc_q + 16'd1;
          end else begin
            bv_d = 1'b1; ba_d = pc_q; pc_d = pc_q + 16'd1; seq_d = c6502_pkg::SqOp1;
          end
        end
        c6502_pkg::SqOp1: begin
          priority if (dc.mode == c6502_pkg::MImm) begin
            if (dc.act == c6502_pkg::ALda) a_d = d;
            else if (dc.act == c6502_pkg::ALdx) x_d = d;
            else y_d = d;
            p_d[c6502_pkg::FlagZ] = (d == 8'd0); p_d[c6502_pkg::FlagN] = d[7];
            bv_d = 1'b1; ba_d = pc_q; ret_d = 1'b1; cost_d = 3'd2;
            pc_d = pc_q + 16'd1; seq_d = c6502_pkg::SqOpcode;
          end else if (dc.mode == c6502_pkg::MRel) begin
            priority case (op_q)
              c6502_pkg::OpBcc: taken = !p_q[c6502_pkg::FlagC];
              c6502_pkg::OpBcs: taken = p_q[c6502_pkg::FlagC];
              c6502_pkg::OpBeq: taken = p_q[c6502_pkg::FlagZ];
              c6502_pkg::OpBne: taken = !p_q[c6502_pkg::FlagZ];
              default:          taken = p_q[c6502_pkg::FlagV];
            endcase
            tgt = pc_q + {{8{d[7]}}, d};
            if (taken) begin
              bcost = (tgt[15:8] != pc_q[15:8]) ? 3'd4 : 3'd3;
            end
            bv_d = 1'b1; ba_d = taken ? tgt : pc_q; ret_d = 1'b1; cost_d = bcost;
            pc_d = (taken ? tgt : pc_q) + 16'd1; seq_d = c6502_pkg::SqOpcode;
          end else if (dc.mode == c6502_pkg::MZp || dc.mode == c6502_pkg::MZpx ||
                       dc.mode == c6502_pkg::MZpy) begin
            idx = (dc.mode == c6502_pkg::MZpx) ? x_q :
                  ((dc.mode == c6502_pkg::MZpy) ? y_q : 8'd0);
            ea_d = {8'd0, d + idx};
            bv_d = 1'b1; ba_d = ea_d; seq_d = c6502_pkg::SqData;
          end else if (dc.mode == c6502_pkg::MIzx || dc.mode == c6502_pkg::MIzy) begin
            pl_d = (dc.mode == c6502_pkg::MIzx) ? d + x_q : d;
            bv_d = 1'b1; ba_d = {8'd0, pl_d}; seq_d = c6502_pkg::SqPtrl;
          end else begin
            pl_d = d;
            bv_d = 1'b1; ba_d = pc_q; pc_d = pc_q + 16'd1; seq_d = c6502_pkg::SqOp2;
          end
        end
        c6502_pkg::SqOp2: begin
          priority if (dc.act == c6502_pkg::AJmp) begin
            bv_d = 1'b1; ba_d = {d, pl_q}; ret_d = 1'b1; cost_d = 3'd3;
            pc_d = {d, pl_q} + 16'd1; seq_d = c6502_pkg::SqOpcode;
          end else if (dc.act == c6502_pkg::AJsr) begin
            ea_d = {d, pl_q};
            bv_d = 1'b1; ba_d = {8'h01, sp_q}; bw_d = 1'b1; bd_d = ret_addr[15:8];
            sp_d = sp_q - 8'd1; seq_d = c6502_pkg::SqPush;
          end else begin
            idx = (dc.mode == c6502_pkg::MAbx) ? x_q :
                  ((dc.mode == c6502_pkg::MAby) ? y_q : 8'd0);
            base = {d, pl_q};
            eidx = base + {8'd0, idx};
            ea_d = eidx;
            pc_x_d = (dc.mode != c6502_pkg::MAbs) && (base[15:8] != eidx[15:8]);
            bv_d = 1'b1; ba_d = eidx; seq_d = c6502_pkg::SqData;
          end
        end
        c6502_pkg::SqPush: begin
          bv_d = 1'b1; ba_d = {8'h01, sp_q}; bw_d = 1'b1; bd_d = ret_addr[7:0];
          sp_d = sp_q - 8'd1; pc_d = ea_q; seq_d = c6502_pkg::SqData;
        end
        c6502_pkg::SqPtrl: begin
          ea_d = {8'd0, d};
          bv_d = 1'b1; ba_d = {8'd0, pl1}; seq_d = c6502_pkg::SqPtrh;
        end
        c6502_pkg::SqPtrh: begin
          pl_d = ea_q[7:0];
          idx = (dc.mode == c6502_pkg::MIzy) ? y_q : 8'd0;
          base = {d, ea_q[7:0]};
          eidx = base + {8'd0, idx};
          ea_d = eidx;
          pc_x_d = (dc.mode == c6502_pkg::MIzy) && (base[15:8] != eidx[15:8]);
          bv_d = 1'b1; ba_d = eidx; seq_d = c6502_pkg::SqData;
        end
        c6502_pkg::SqData: begin
          if (dc.act == c6502_pkg::AJsr) begin
            cost_d = 3'd6;
          end else begin
            if (dc.act == c6502_pkg::ALda) a_d = d;
            if (dc.act == c6502_pkg::ALdx) x_d = d;
            if (dc.act == c6502_pkg::ALdy) y_d = d;
            if (dc.act == c6502_pkg::ALda || dc.act == c6502_pkg::ALdx ||
                dc.act == c6502_pkg::ALdy) begin
              p_d[c6502_pkg::FlagZ] = (d == 8'd0); p_d[c6502_pkg::FlagN] = d[7];
            end
            if (dc.act == c6502_pkg::ABit) begin
              p_d[c6502_pkg::FlagZ] = ((d & a_q) == 8'd0);
              p_d[c6502_pkg::FlagV] = d[6]; p_d[c6502_pkg::FlagN] = d[7];
            end
            cost_d = c6502_pkg::cost_of(dc.mode, dc.act, pc_x_q);
          end
          bv_d = 1'b1; ba_d = pc_q; ret_d = 1'b1;
          pc_d = pc_q + 16'd1; seq_d = c6502_pkg::SqOpcode;
        end
        default: begin
          bv_d = 1'b1; ba_d = start_q; pc_d = start_q + 16'd1;
          seq_d = c6502_pkg::SqOpcode;
        end
      endcase
      if (seq_q == c6502_pkg::SqOp2 || seq_q == c6502_pkg::SqPtrh ||
          (seq_q == c6502_pkg::SqOp1 && (dc.mode == c6502_pkg::MZp ||
           dc.mode == c6502_pkg::MZpx || dc.mode == c6502_pkg::MZpy))) begin
        if (dc.act == c6502_pkg::ASta || dc.act == c6502_pkg::AStx ||
            dc.act == c6502_pkg::ASty) begin
          bw_d = 1'b1;
          bd_d = (dc.act == c6502_pkg::ASta) ? a_q :
                 ((dc.act == c6502_pkg::AStx) ? x_q : y_q);
        end
      end
    end
    if (halt_d) begin
      bv_d = 1'b0; ba_d = '0; bw_d = 1'b0; bd_d = '0; ret_d = 1'b0; cost_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= c6502_pkg::ResetStart;
      seq_q <= c6502_pkg::SqStart;
      pc_q <= c6502_pkg::ResetStart; ea_q <= '0;
      a_q <= '0; x_q <= '0; y_q <= '0;
      sp_q <= c6502_pkg::ResetSp; p_q <= c6502_pkg::ResetStatus;
      op_q <= '0; pl_q <= '0; pc_x_q <= 1'b0; halt_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_valid_i) start_q <= cfg_start_address_i;
      if (accept) begin
        seq_q <= seq_d; pc_q <= pc_d; ea_q <= ea_d;
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
        op_q <= op_d; pl_q <= pl_d; pc_x_q <= pc_x_d; halt_q <= halt_d;
      end
      if (accept) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bv_q <= bv_d; ba_q <= ba_d; bw_q <= bw_d; bd_q <= bd_d;
      ret_q <= ret_d; cost_q <= cost_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign bus_valid_o      = bv_q;
  assign bus_address_o    = ba_q;
  assign bus_write_o      = bw_q;
  assign bus_write_data_o = bd_q;
  assign retired_o        = ret_q;
  assign cycle_cost_o     = cost_q;
  assign halted_o         = halt_q;
  assign acc_value_o      = a_q;
  assign x_value_o        = x_q;
  assign y_value_o        = y_q;
  assign status_value_o   = p_q;

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q) else $error("halt cleared");
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && halt_d) |=> !bus_valid_o && !retired_o) else $error("access while halted");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(ba_q)) else $error("result lost");
  a_write_no_retire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && bw_d |-> !ret_d) else $error("write marked retired");

endmodule

// File: dv/cpu6502_subset_bus_core_test.sv
// ----------------------------------------------------------------------------
// 6502 subset bus core testbench
// Feeds read bytes as instruction streams chosen from the predicted sequencer
// step, predicts each bus access and register snapshot, and compares every
// result in order. Covers start address setup, all supported opcodes, page
// wraps, branch page crossings, JSR pushes and the halt on an unknown opcode.
// ----------------------------------------------------------------------------
module cpu6502_subset_bus_core_test;

  localparam logic [7:0] OpLdaImm = 8'hA9, OpLdaZp = 8'hA5, OpLdaZpx = 8'hB5;
  localparam logic [7:0] OpLdaAbs = 8'hAD, OpLdaAbx = 8'hBD, OpLdaAby = 8'hB9;
  localparam logic [7:0] OpLdaIzx = 8'hA1, OpLdaIzy = 8'hB1;
  localparam logic [7:0] OpStaZp = 8'h85, OpStaZpx = 8'h95, OpStaAbs = 8'h8D;
  localparam logic [7:0] OpStaAbx = 8'h9D, OpStaAby = 8'h99;
  localparam logic [7:0] OpStaIzx = 8'h81, OpStaIzy = 8'h91;
  localparam logic [7:0] OpLdxImm = 8'hA2, OpLdxZp = 8'hA6, OpLdxAbs = 8'hAE;
  localparam logic [7:0] OpLdxZpy = 8'hB6, OpLdxAby = 8'hBE;
  localparam logic [7:0] OpLdyImm = 8'hA0, OpLdyZp = 8'hA4, OpLdyAbs = 8'hAC;
  localparam logic [7:0] OpLdyZpx = 8'hB4, OpLdyAbx = 8'hBC;
  localparam logic [7:0] OpStxZp = 8'h86, OpStxZpy = 8'h96, OpStxAbs = 8'h8E;
  localparam logic [7:0] OpStyZp = 8'h84, OpStyZpx = 8'h94, OpStyAbs = 8'h8C;
  localparam logic [7:0] OpBitZp = 8'h24, OpBitAbs = 8'h2C, OpBvs = 8'h70;
  localparam logic [7:0] OpClc = 8'h18, OpSec = 8'h38, OpInx = 8'hE8;
  localparam logic [7:0] OpIny = 8'hC8, OpNop = 8'hEA, OpJmp = 8'h4C;
  localparam logic [7:0] OpJsr = 8'h20, OpUnknown = 8'h02;

  localparam logic [7:0] KnownOps [43] = '{
    OpLdaImm, OpLdaZp, OpLdaZpx, OpLdaAbs, OpLdaAbx, OpLdaAby, OpLdaIzx, OpLdaIzy,
    OpStaZp, OpStaZpx, OpStaAbs, OpStaAbx, OpStaAby, OpStaIzx, OpStaIzy,
    OpLdxImm, OpLdxZp, OpLdxAbs, OpLdxZpy, OpLdxAby,
    OpLdyImm, OpLdyZp, OpLdyAbs, OpLdyZpx, OpLdyAbx,
    OpStxZp, OpStxZpy, OpStxAbs, OpStyZp, OpStyZpx, OpStyAbs,
    OpBitZp, OpBitAbs, c6502_pkg::OpBcc, c6502_pkg::OpBcs, c6502_pkg::OpBeq,
    c6502_pkg::OpBne, OpBvs,
    OpClc, OpSec, OpInx, OpIny, OpNop
  };

  typedef struct {
    logic        bus_valid;
    logic [15:0] bus_address;
    logic        bus_write;
    logic [7:0]  bus_write_data;
    logic        retired;
    logic [2:0]  cycle_cost;
    logic        halted;
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  status;
  } bus_access_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_start_address_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  read_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        bus_valid_o;
  logic [15:0] bus_address_o;
  logic        bus_write_o;
  logic [7:0]  bus_write_data_o;
  logic        retired_o;
  logic [2:0]  cycle_cost_o;
  logic        halted_o;
  logic [7:0]  acc_value_o;
  logic [7:0]  x_value_o;
  logic [7:0]  y_value_o;
  logic [7:0]  status_value_o;

  cpu6502_subset_bus_core dut (.*);

  bus_access_t expected_accesses[$];
  bus_access_t next_access;
  int unsigned failures = 0;
  bit          idle_on = 1'b1;

  // core model state
  logic [15:0]     start_cfg, pc, eff_addr;
  logic [7:0]      acc_r, x_r, y_r, sp_r, p_r, cur_op, ptr_lo;
  c6502_pkg::seq_e step;
  logic            crossed, halt;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) out_stall_i <= idle_on && ($urandom_range(99) < 10);

  function automatic bit decode_op(input logic [7:0] op, output c6502_pkg::mode_e m,
                                   output c6502_pkg::act_e a);
    m = c6502_pkg::MImp;
    a = c6502_pkg::ANop;
    case (op)
      OpLdaImm: begin a = c6502_pkg::ALda; m = c6502_pkg::MImm; end
      OpLdaZp:  begin a = c6502_pkg::ALda; m = c6502_pkg::MZp; end
      OpLdaZpx: begin a = c6502_pkg::ALda; m = c6502_pkg::MZpx; end
      OpLdaAbs: begin a = c6502_pkg::ALda; m = c6502_pkg::MAbs; end
      OpLdaAbx: begin a = c6502_pkg::ALda; m = c6502_pkg::MAbx; end
      OpLdaAby: begin a = c6502_pkg::ALda; m = c6502_pkg::MAby; end
      OpLdaIzx: begin a = c6502_pkg::ALda; m = c6502_pkg::MIzx; end
      OpLdaIzy: begin a = c6502_pkg::ALda; m = c6502_pkg::MIzy; end
      OpStaZp:  begin a = c6502_pkg::ASta; m = c6502_pkg::MZp; end
      OpStaZpx: begin a = c6502_pkg::ASta; m = c6502_pkg::MZpx; end
      OpStaAbs: begin a = c6502_pkg::ASta; m = c6502_pkg::MAbs; end
      OpStaAbx: begin a = c6502_pkg::ASta; m = c6502_pkg::MAbx; end
      OpStaAby: begin a = c6502_pkg::ASta; m = c6502_pkg::MAby; end
      OpStaIzx: begin a = c6502_pkg::ASta; m = c6502_pkg::MIzx; end
      OpStaIzy: begin a = c6502_pkg::ASta; m = c6502_pkg::MIzy; end
      OpLdxImm: begin a = c6502_pkg::ALdx; m = c6502_pkg::MImm; end
      OpLdxZp:  begin a = c6502_pkg::ALdx; m = c6502_pkg::MZp; end
      OpLdxAbs: begin a = c6502_pkg::ALdx; m = c6502_pkg::MAbs; end
      OpLdxZpy: begin a = c6502_pkg::ALdx; m = c6502_pkg::MZpy; end
      OpLdxAby: begin a = c6502_pkg::ALdx; m = c6502_pkg::MAby; end
      OpLdyImm: begin a = c6502_pkg::ALdy; m = c6502_pkg::MImm; end
      OpLdyZp:  begin a = c6502_pkg::ALdy; m = c6502_pkg::MZp; end
      OpLdyAbs: begin a = c6502_pkg::ALdy; m = c6502_pkg::MAbs; end
      OpLdyZpx: begin a = c6502_pkg::ALdy; m = c6502_pkg::MZpx; end
      OpLdyAbx: begin a = c6502_pkg::ALdy; m = c6502_pkg::MAbx; end
      OpStxZp:  begin a = c6502_pkg::AStx; m = c6502_pkg::MZp; end
      OpStxZpy: begin a = c6502_pkg::AStx; m = c6502_pkg::MZpy; end
      OpStxAbs: begin a = c6502_pkg::AStx; m = c6502_pkg::MAbs; end
      OpStyZp:  begin a = c6502_pkg::ASty; m = c6502_pkg::MZp; end
      OpStyZpx: begin a = c6502_pkg::ASty; m = c6502_pkg::MZpx; end
      OpStyAbs: begin a = c6502_pkg::ASty; m = c6502_pkg::MAbs; end
      OpBitZp:  begin a = c6502_pkg::ABit; m = c6502_pkg::MZp; end
      OpBitAbs: begin a = c6502_pkg::ABit; m = c6502_pkg::MAbs; end
      c6502_pkg::OpBcc, c6502_pkg::OpBcs, c6502_pkg::OpBeq, c6502_pkg::OpBne,
      OpBvs: begin a = c6502_pkg::ABr; m = c6502_pkg::MRel; end
      OpClc: a = c6502_pkg::AClc;
      OpSec: a = c6502_pkg::ASec;
      OpInx: a = c6502_pkg::AInx;
      OpIny: a = c6502_pkg::AIny;
      OpNop: a = c6502_pkg::ANop;
      OpJmp: begin a = c6502_pkg::AJmp; m = c6502_pkg::MAbs; end
      OpJsr: begin a = c6502_pkg::AJsr; m = c6502_pkg::MAbs; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [2:0] instr_cycles(input c6502_pkg::mode_e m,
                                              input c6502_pkg::act_e a, input logic cr);
    logic c;
    c = cr | (a == c6502_pkg::ASta);
    case (m)
      c6502_pkg::MImm: return 3'd2;
      c6502_pkg::MZp: return 3'd3;
      c6502_pkg::MZpx, c6502_pkg::MZpy, c6502_pkg::MAbs: return 3'd4;
      c6502_pkg::MAbx, c6502_pkg::MAby: return c ? 3'd5 : 3'd4;
      c6502_pkg::MIzx: return 3'd6;
      c6502_pkg::MIzy: return c ? 3'd6 : 3'd5;
      default: return 3'd2;
    endcase
  endfunction

  function automatic void emit(input logic [15:0] addr, input logic wr, input logic [7:0] wd,
                               input logic ret, input logic [2:0] cost);
    next_access.bus_valid = 1'b1;
    next_access.bus_address = addr;
    next_access.bus_write = wr;
    next_access.bus_write_data = wd;
    next_access.retired = ret;
    next_access.cycle_cost = cost;
  endfunction

  function automatic void fetch_opcode(input logic ret, input logic [2:0] cost);
    emit(pc, 1'b0, 8'h00, ret, cost);
    pc = pc + 16'd1;
    step = c6502_pkg::SqOpcode;
  endfunction

  function automatic void set_nz(input logic [7:0] v);
    p_r[c6502_pkg::FlagZ] = (v == 8'h00);
    p_r[c6502_pkg::FlagN] = v[7];
  endfunction

  function automatic void operand_access(input c6502_pkg::act_e a);
    case (a)
      c6502_pkg::ASta: emit(eff_addr, 1'b1, acc_r, 1'b0, 3'd0);
      c6502_pkg::AStx: emit(eff_addr, 1'b1, x_r, 1'b0, 3'd0);
      c6502_pkg::ASty: emit(eff_addr, 1'b1, y_r, 1'b0, 3'd0);
      default: emit(eff_addr, 1'b0, 8'h00, 1'b0, 3'd0);
    endcase
    step = c6502_pkg::SqData;
  endfunction

  function automatic void index_from(input logic [7:0] hi, input logic [7:0] idx);
    logic [15:0] base;
    base = {hi, ptr_lo};
    eff_addr = base + {8'h00, idx};
    crossed = base[15:8] != eff_addr[15:8];
  endfunction

  function automatic bit branch_taken(input logic [7:0] op);
    case (op)
      c6502_pkg::OpBcc: return !p_r[c6502_pkg::FlagC];
      c6502_pkg::OpBcs: return p_r[c6502_pkg::FlagC];
      c6502_pkg::OpBeq: return p_r[c6502_pkg::FlagZ];
      c6502_pkg::OpBne: return !p_r[c6502_pkg::FlagZ];
      default: return p_r[c6502_pkg::FlagV];
    endcase
  endfunction

  function automatic void reset_core();
    start_cfg = c6502_pkg::ResetStart;
    pc = c6502_pkg::ResetStart;
    acc_r = '0; x_r = '0; y_r = '0;
    sp_r = c6502_pkg::ResetSp;
    p_r = c6502_pkg::ResetStatus;
    cur_op = '0;
    step = c6502_pkg::SqStart;
    eff_addr = '0;
    ptr_lo = '0;
    crossed = 1'b0;
    halt = 1'b0;
  endfunction

  function automatic void predict_access(input logic [7:0] d);
    c6502_pkg::mode_e m;
    c6502_pkg::act_e a;
    logic [15:0] tgt, ret_addr;
    logic [2:0] c;
    logic [7:0] idx;
    void'(decode_op(cur_op, m, a));
    next_access = '{default: '0};
    if (!halt) begin
      case (step)
        c6502_pkg::SqOpcode: begin
          cur_op = d;
          crossed = 1'b0;
          if (!decode_op(d, m, a)) begin
            halt = 1'b1;
          end else if (m == c6502_pkg::MImp) begin
            case (a)
              c6502_pkg::AClc: p_r[c6502_pkg::FlagC] = 1'b0;
              c6502_pkg::ASec: p_r[c6502_pkg::FlagC] = 1'b1;
              c6502_pkg::AInx: begin x_r = x_r + 8'd1; set_nz(x_r); end
              c6502_pkg::AIny: begin y_r = y_r + 8'd1; set_nz(y_r); end
              default: ;
            endcase
            fetch_opcode(1'b1, 3'd2);
          end else begin
            emit(pc, 1'b0, 8'h00, 1'b0, 3'd0);
            step = c6502_pkg::SqOp1;
            pc = pc + 16'd1;
          end
        end
        c6502_pkg::SqOp1: begin
          if (m == c6502_pkg::MImm) begin
            case (a)
              c6502_pkg::ALda: acc_r = d;
              c6502_pkg::ALdx: x_r = d;
              default: y_r = d;
            endcase
            set_nz(d);
            fetch_opcode(1'b1, 3'd2);
          end else if (m == c6502_pkg::MRel) begin
            c = 3'd2;
            if (branch_taken(cur_op)) begin
              tgt = pc + {{8{d[7]}}, d};
              c = c + 3'd1;
              if (tgt[15:8] != pc[15:8]) c = c + 3'd1;
              pc = tgt;
            end
            fetch_opcode(1'b1, c);
          end else if (m == c6502_pkg::MZp || m == c6502_pkg::MZpx ||
                       m == c6502_pkg::MZpy) begin
            idx = (m == c6502_pkg::MZpx) ? x_r : ((m == c6502_pkg::MZpy) ? y_r : 8'h00);
            eff_addr = {8'h00, d + idx};
            operand_access(a);
          end else if (m == c6502_pkg::MIzx || m == c6502_pkg::MIzy) begin
            ptr_lo = (m == c6502_pkg::MIzx) ? d + x_r : d;
            emit({8'h00, ptr_lo}, 1'b0, 8'h00, 1'b0, 3'd0);
            step = c6502_pkg::SqPtrl;
          end else begin
            ptr_lo = d;
            emit(pc, 1'b0, 8'h00, 1'b0, 3'd0);
            step = c6502_pkg::SqOp2;
            pc = pc + 16'd1;
          end
        end
        c6502_pkg::SqOp2: begin
          if (a == c6502_pkg::AJmp) begin
            pc = {d, ptr_lo};
            fetch_opcode(1'b1, 3'd3);
          end else if (a == c6502_pkg::AJsr) begin
            ret_addr = pc - 16'd1;
            eff_addr = {d, ptr_lo};
            emit({8'h01, sp_r}, 1'b1, ret_addr[15:8], 1'b0, 3'd0);
            sp_r = sp_r - 8'd1;
            step = c6502_pkg::SqPush;
          end else begin
            index_from(d, (m == c6502_pkg::MAbx) ? x_r :
                          ((m == c6502_pkg::MAby) ? y_r : 8'h00));
            if (m == c6502_pkg::MAbs) crossed = 1'b0;
            operand_access(a);
          end
        end
        c6502_pkg::SqPush: begin
          ret_addr = pc - 16'd1;
          emit({8'h01, sp_r}, 1'b1, ret_addr[7:0], 1'b0, 3'd0);
          sp_r = sp_r - 8'd1;
          pc = eff_addr;
          step = c6502_pkg::SqData;
        end
        c6502_pkg::SqPtrl: begin
          eff_addr = {8'h00, d};
          emit({8'h00, ptr_lo + 8'd1}, 1'b0, 8'h00, 1'b0, 3'd0);
          step = c6502_pkg::SqPtrh;
        end
        c6502_pkg::SqPtrh: begin
          ptr_lo = eff_addr[7:0];
          index_from(d, (m == c6502_pkg::MIzy) ? y_r : 8'h00);
          if (m != c6502_pkg::MIzy) crossed = 1'b0;
          operand_access(a);
        end
        c6502_pkg::SqData: begin
          if (a == c6502_pkg::AJsr) begin
            fetch_opcode(1'b1, 3'd6);
          end else begin
            case (a)
              c6502_pkg::ALda: begin acc_r = d; set_nz(d); end
              c6502_pkg::ALdx: begin x_r = d; set_nz(d); end
              c6502_pkg::ALdy: begin y_r = d; set_nz(d); end
              c6502_pkg::ABit: begin
                p_r[c6502_pkg::FlagZ] = (d & acc_r) == 8'h00;
                p_r[c6502_pkg::FlagV] = d[6];
                p_r[c6502_pkg::FlagN] = d[7];
              end
              default: ;
            endcase
            fetch_opcode(1'b1, instr_cycles(m, a, crossed));
          end
        end
        default: begin
          pc = start_cfg;
          fetch_opcode(1'b0, 3'd0);
        end
      endcase
    end
    if (halt) next_access = '{default: '0};
    next_access.halted = halt;
    next_access.acc = acc_r;
    next_access.x = x_r;
    next_access.y = y_r;
    next_access.status = p_r;
    expected_accesses.push_back(next_access);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin
    bus_access_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_accesses.size() == 0) begin
        $error("result with no request outstanding");
        failures++;
      end else begin
        e = expected_accesses.pop_front();
        check_field("bus_valid", e.bus_valid, bus_valid_o);
        check_field("bus_address", e.bus_address, bus_address_o);
        check_field("bus_write", e.bus_write, bus_write_o);
        check_field("bus_write_data", e.bus_write_data, bus_write_data_o);
        check_field("retired", e.retired, retired_o);
        check_field("cycle_cost", e.cycle_cost, cycle_cost_o);
        check_field("halted", e.halted, halted_o);
        check_field("acc_value", e.acc, acc_value_o);
        check_field("x_value", e.x, x_value_o);
        check_field("y_value", e.y, y_value_o);
        check_field("status_value", e.status, status_value_o);
      end
    end
  end

  task automatic send_read(input logic [7:0] d);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    read_data_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_access(d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (expected_accesses.size() == 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_start(input logic [15:0] addr);
    cfg_valid_i <= 1'b1;
    cfg_start_address_i <= addr;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    start_cfg = addr;
  endtask

  // opcode first, then operand/data bytes until the next opcode fetch
  task automatic run_instr(input logic [7:0] op,
                           input logic [7:0] b0 = 8'($urandom_range(255)),
                           input logic [7:0] b1 = 8'($urandom_range(255)),
                           input logic [7:0] b2 = 8'($urandom_range(255)),
                           input logic [7:0] b3 = 8'($urandom_range(255)));
    logic [7:0] bytes [4];
    int i;
    bytes = '{b0, b1, b2, b3};
    i = 0;
    send_read(op);
    while (step != c6502_pkg::SqOpcode && !halt) begin
      send_read(i < 4 ? bytes[i] : 8'($urandom_range(255)));
      i++;
    end
  endtask

  task automatic test_start_address();
    write_start(16'h0000);
    write_start(16'hFFFE);
    send_read(8'($urandom_range(255)));
  endtask

  task automatic test_directed();
    run_instr(OpLdaImm, 8'h80);
    run_instr(OpLdaImm, 8'h00);
    run_instr(OpLdxImm, 8'hFF);
    run_instr(OpLdyImm, 8'h01);
    run_instr(OpStaZp, 8'hFF);
    run_instr(OpLdaZpx, 8'h05, 8'h7F);
    run_instr(OpLdaAbx, 8'h01, 8'h80, 8'hC0);
    run_instr(OpLdaAby, 8'hFF, 8'hFF, 8'h40);
    run_instr(OpStaAbx, 8'h00, 8'h20);
    run_instr(OpLdaIzx, 8'h00, 8'h34, 8'h12, 8'hFF);
    run_instr(OpStaIzy, 8'hFF, 8'hFF, 8'hFF);
    run_instr(OpLdxZpy, 8'hFF, 8'h00);
    run_instr(OpLdyAbx, 8'hFF, 8'h00, 8'h80);
    run_instr(OpStxAbs, 8'h00, 8'hFF);
    run_instr(OpStyZpx, 8'hFF);
    run_instr(OpBitZp, 8'h10, 8'hC0);
    run_instr(OpBitAbs, 8'h00, 8'h10, 8'h00);
    run_instr(OpBvs, 8'h80);
    run_instr(OpClc);
    run_instr(c6502_pkg::OpBcc, 8'h80);
    run_instr(OpSec);
    run_instr(c6502_pkg::OpBcs, 8'h7F);
    run_instr(c6502_pkg::OpBeq, 8'h10);
    run_instr(c6502_pkg::OpBne, 8'hFE);
    run_instr(OpInx);
    run_instr(OpIny);
    run_instr(OpNop);
    run_instr(OpJmp, 8'hF0, 8'h01);
    run_instr(OpJsr, 8'h00, 8'h80);
    drain();
  endtask

  task automatic test_config_idle();
    write_start(16'hFFFF);
    run_instr(OpLdaImm, 8'h7F);
    drain();
    write_start(16'($urandom_range(16'hFFFF)));
    run_instr(OpNop);
    drain();
    write_start(16'h0000);
  endtask

  task automatic test_random_programs();
    int unsigned n;
    logic [7:0] op;
    for (n = 0; n < 360; n++) begin
      if (n == 150) idle_on = 1'b0;
      if (n == 250) idle_on = 1'b1;
      if (n == 300) drain();
      case ($urandom_range(19))
        0: op = OpJmp;
        1: op = OpJsr;
        default: op = KnownOps[$urandom_range(42)];
      endcase
      run_instr(op);
    end
    drain();
  endtask

  task automatic test_halt();
    run_instr(OpLdxImm, 8'h55);
    send_read(OpUnknown);
    repeat (6) send_read(8'($urandom_range(255)));
    drain();
  endtask

  initial begin
    reset_core();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_start_address();
    test_directed();
    test_config_idle();
    test_random_programs();
    test_halt();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/c6502_pkg.sv
rtl/cpu6502_subset_bus_core.sv
dv/cpu6502_subset_bus_core_test.sv
